@@ hdl/bdm_pkg.sv @@
// shared constants for the block mode downsample core
`timescale 1ns / 1ps

package bdm_pkg;

    localparam int LEVEL_W        = 8;
    localparam int CNT_W          = 10;
    localparam int NUM_LEVELS_DEF = 256;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

endpackage

@@ hdl/bdm_ram.sv @@
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module bdm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/block_mode_downsample_core.sv @@
// block mode downsample core: running histogram mode of one voxel block
`timescale 1ns / 1ps

// channel   dir  handshake                 payload
// s         in   i_s_tvalid / o_s_tready   i_s_tdata = voxel_value, i_s_tlast = last_in_block
// m         out  o_m_tvalid / i_m_tready   o_m_tdata = mode_value
//
// one beat per cycle sustained, but for a last beat held in stage 1; each beat does one
// histogram read, increment, compare and write in stage 1, with the bin read out of the ram as it enters
// a result sits in the output register once its last beat commits from stage 1
// reset clears the histogram at once through per-bin valid bits, no sweep
// only a last beat waits in stage 1, and only while the output register is full and not taken

module block_mode_downsample_core #(
    parameter int NUM_LEVELS = bdm_pkg::NUM_LEVELS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [bdm_pkg::LEVEL_W-1:0] i_s_tdata,   // [7:0] voxel_value
    input  logic                        i_s_tlast,   // last_in_block
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [bdm_pkg::LEVEL_W-1:0] o_m_tdata    // [7:0] mode_value
);

    import bdm_pkg::*;

    localparam int LVL_W = $clog2(NUM_LEVELS);

    // stage 1: beat whose bin count is being read out of the ram
    logic             r_s1_valid;
    logic             r_s1_last;
    logic [LVL_W-1:0] r_s1_lvl;
    logic             r_s1_fwd;     // bin was written on the edge the beat came in
    logic [CNT_W-1:0] r_s1_fcnt;    // count written on that edge
    logic             r_s1_vbit;    // bin already touched in this block

    // running winner and per-bin valid bits
    logic [NUM_LEVELS-1:0] r_vld;
    logic [CNT_W-1:0]      r_best_cnt;
    logic [LVL_W-1:0]      r_best_lvl;

    // output register
    logic             r_out_valid;
    logic [LVL_W-1:0] r_out_lvl;

    logic             s_accept;
    logic             s1_go;
    logic [LVL_W-1:0] in_lvl;
    logic [CNT_W-1:0] ram_rdata;
    logic [CNT_W-1:0] old_cnt;
    logic [CNT_W-1:0] new_cnt;
    logic             upd;
    logic [LVL_W-1:0] win_lvl;
    logic             n_fwd;
    logic             n_vbit;

    // values beyond the levels land in the top bin
    always_comb begin
        if (32'(i_s_tdata) >= NUM_LEVELS) begin
            in_lvl = LVL_W'(NUM_LEVELS - 1);
        end else begin
            in_lvl = i_s_tdata[LVL_W-1:0];
        end
    end

    // a non-last beat always commits; a last beat needs room for its result
    assign s1_go      = r_s1_valid && (!r_s1_last || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_s1_valid || s1_go;
    assign s_accept   = i_s_tvalid && o_s_tready;

    bdm_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_LEVELS)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (s1_go),
        .i_waddr (r_s1_lvl),
        .i_wdata (new_cnt),
        .i_re    (s_accept),
        .i_raddr (in_lvl),
        .o_rdata (ram_rdata)
    );

    // increment with saturation, strict compare keeps the earliest on a tie
    always_comb begin
        if (r_s1_fwd) begin
            old_cnt = r_s1_fcnt;
        end else if (r_s1_vbit) begin
            old_cnt = ram_rdata;
        end else begin
            old_cnt = '0;
        end
        new_cnt = (old_cnt < COUNT_MAX) ? old_cnt + 1'b1 : old_cnt;
        upd     = new_cnt > r_best_cnt;
        win_lvl = upd ? r_s1_lvl : r_best_lvl;
    end

    // the ram read on the commit edge misses that write, and a block end
    // clears every bin the incoming beat could see
    always_comb begin
        n_fwd  = s1_go && !r_s1_last && (r_s1_lvl == in_lvl);
        n_vbit = (s1_go && r_s1_last) ? 1'b0 : r_vld[in_lvl];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_vld       <= '0;
            r_best_cnt  <= '0;
            r_best_lvl  <= '0;
        end else begin
            if (s_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_go) begin
                if (r_s1_last) begin
                    r_vld      <= '0;
                    r_best_cnt <= '0;
                    r_best_lvl <= '0;
                end else begin
                    r_vld[r_s1_lvl] <= 1'b1;
                    if (upd) begin
                        r_best_cnt <= new_cnt;
                        r_best_lvl <= r_s1_lvl;
                    end
                end
            end

            if (s1_go && r_s1_last) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_last <= i_s_tlast;
            r_s1_lvl  <= in_lvl;
            r_s1_fwd  <= n_fwd;
            r_s1_fcnt <= new_cnt;
            r_s1_vbit <= n_vbit;
        end
        if (s1_go && r_s1_last) begin
            r_out_lvl <= win_lvl;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = LEVEL_W'(r_out_lvl);

    // block end leaves the bin valid bits and the winning count cleared
    a_block_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && r_s1_last) |=> (r_best_cnt == '0 && r_vld == '0))
        else $error("histogram not cleared after block end");

    // a result only appears after a last beat commits
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(s1_go && r_s1_last))
        else $error("result without a last beat");

    // a forwarded count always comes from a committed beat
    a_fwd_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_fwd) |-> (r_s1_fcnt != '0))
        else $error("forwarded count is zero");

    // a committed non-last beat leaves its bin marked and the best count nonzero
    a_commit_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && !r_s1_last) |=> (r_vld[$past(r_s1_lvl)] && r_best_cnt != '0))
        else $error("bin or winner not updated by commit");

endmodule
